>>> rtl/core/hdvs_pkg.sv
package hdvs_pkg;

  // Microprogram geometry.
  localparam int unsigned RomDepth = 88;
  localparam int unsigned UpcW     = $clog2(RomDepth);
  localparam int unsigned LenW     = 5;
  localparam int unsigned OffW     = 5;

  // Stroke lengths used by the glyph set.
  localparam logic [LenW-1:0] Len4  = LenW'(4);
  localparam logic [LenW-1:0] Len8  = LenW'(8);
  localparam logic [LenW-1:0] Len16 = LenW'(16);

  // Payload of one input transfer.
  typedef struct packed {
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [3:0] glyph_code;
  } in_item_t;

  // Payload of one output transfer.
  typedef struct packed {
    logic [7:0] beam_x;
    logic [7:0] beam_y;
    logic       last_point;
  } out_item_t;

  // Microinstruction opcodes.
  typedef enum logic {
    OP_ORG,
    OP_STROKE
  } op_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // One control word of the microprogram.
  typedef struct packed {
    op_e             op;
    logic [OffW-1:0] off_x;
    logic [OffW-1:0] off_y;
    logic            axis_y;
    logic            neg;
    logic [LenW-1:0] len;
    logic            eop;
  } ucode_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic            load;
    logic            add_off;
    logic [OffW-1:0] off_x;
    logic [OffW-1:0] off_y;
    logic            emit;
    logic            step;
    logic            axis_y;
    logic            neg;
    logic            last;
  } dp_ctrl_t;

  // Word that moves the beam to the glyph's starting offset.
  function automatic ucode_t mk_org(logic [OffW-1:0] sx, logic [OffW-1:0] sy);
    ucode_t w;
    w        = '0;
    w.op     = OP_ORG;
    w.off_x  = sx;
    w.off_y  = sy;
    return w;
  endfunction

  // Word that traces one straight stroke.
  function automatic ucode_t mk_stk(logic axis_y, logic neg, logic [LenW-1:0] len,
                                    logic eop);
    ucode_t w;
    w        = '0;
    w.op     = OP_STROKE;
    w.axis_y = axis_y;
    w.neg    = neg;
    w.len    = len;
    w.eop    = eop;
    return w;
  endfunction

  // Shorthands: horizontal/vertical, positive/negative.
  function automatic ucode_t hp(logic [LenW-1:0] len, logic eop);
    return mk_stk(1'b0, 1'b0, len, eop);
  endfunction
  function automatic ucode_t hn(logic [LenW-1:0] len, logic eop);
    return mk_stk(1'b0, 1'b1, len, eop);
  endfunction
  function automatic ucode_t vp(logic [LenW-1:0] len, logic eop);
    return mk_stk(1'b1, 1'b0, len, eop);
  endfunction
  function automatic ucode_t vn(logic [LenW-1:0] len, logic eop);
    return mk_stk(1'b1, 1'b1, len, eop);
  endfunction

  // Microprogram ROM. Each glyph opens with an origin word and ends
  // with a stroke whose end-of-program bit returns the sequencer to idle.
  function automatic ucode_t ucode_rom(logic [UpcW-1:0] addr);
    ucode_t w;
    case (addr)
      // Digit 0.
      7'd0:  w = mk_org(5'd0, 5'd0);
      7'd1:  w = vp(Len16, 1'b0);
      7'd2:  w = hp(Len8, 1'b0);
      7'd3:  w = vn(Len16, 1'b0);
      7'd4:  w = hn(Len8, 1'b1);
      // Digit 1.
      7'd5:  w = mk_org(5'd8, 5'd0);
      7'd6:  w = vp(Len16, 1'b0);
      7'd7:  w = vn(Len16, 1'b1);
      // Digit 2.
      7'd8:  w = mk_org(5'd0, 5'd16);
      7'd9:  w = hp(Len8, 1'b0);
      7'd10: w = vn(Len8, 1'b0);
      7'd11: w = hn(Len8, 1'b0);
      7'd12: w = vn(Len8, 1'b0);
      7'd13: w = hp(Len8, 1'b1);
      // Digit 3.
      7'd14: w = mk_org(5'd0, 5'd16);
      7'd15: w = hp(Len8, 1'b0);
      7'd16: w = vn(Len8, 1'b0);
      7'd17: w = hn(Len8, 1'b0);
      7'd18: w = hp(Len8, 1'b0);
      7'd19: w = vn(Len8, 1'b0);
      7'd20: w = hn(Len8, 1'b1);
      // Digit 4.
      7'd21: w = mk_org(5'd0, 5'd16);
      7'd22: w = vn(Len8, 1'b0);
      7'd23: w = hp(Len8, 1'b0);
      7'd24: w = vp(Len8, 1'b0);
      7'd25: w = vn(Len16, 1'b1);
      // Digit 5.
      7'd26: w = mk_org(5'd8, 5'd16);
      7'd27: w = hn(Len8, 1'b0);
      7'd28: w = vn(Len8, 1'b0);
      7'd29: w = hp(Len8, 1'b0);
      7'd30: w = vn(Len8, 1'b0);
      7'd31: w = hn(Len8, 1'b1);
      // Digit 6.
      7'd32: w = mk_org(5'd8, 5'd16);
      7'd33: w = hn(Len8, 1'b0);
      7'd34: w = vn(Len16, 1'b0);
      7'd35: w = hp(Len8, 1'b0);
      7'd36: w = vp(Len8, 1'b0);
      7'd37: w = hn(Len8, 1'b1);
      // Digit 7.
      7'd38: w = mk_org(5'd0, 5'd16);
      7'd39: w = hp(Len8, 1'b0);
      7'd40: w = vn(Len16, 1'b1);
      // Digit 8.
      7'd41: w = mk_org(5'd0, 5'd8);
      7'd42: w = vp(Len8, 1'b0);
      7'd43: w = hp(Len8, 1'b0);
      7'd44: w = vn(Len8, 1'b0);
      7'd45: w = hn(Len8, 1'b0);
      7'd46: w = vn(Len8, 1'b0);
      7'd47: w = hp(Len8, 1'b0);
      7'd48: w = vp(Len8, 1'b1);
      // Digit 9.
      7'd49: w = mk_org(5'd8, 5'd8);
      7'd50: w = hn(Len8, 1'b0);
      7'd51: w = vp(Len8, 1'b0);
      7'd52: w = hp(Len8, 1'b0);
      7'd53: w = vn(Len16, 1'b1);
      // Letter A.
      7'd54: w = mk_org(5'd0, 5'd12);
      7'd55: w = hp(Len8, 1'b0);
      7'd56: w = vn(Len4, 1'b0);
      7'd57: w = vn(Len8, 1'b0);
      7'd58: w = hn(Len8, 1'b0);
      7'd59: w = vp(Len8, 1'b0);
      7'd60: w = hp(Len8, 1'b1);
      // Letter b.
      7'd61: w = mk_org(5'd0, 5'd16);
      7'd62: w = vn(Len16, 1'b0);
      7'd63: w = hp(Len8, 1'b0);
      7'd64: w = vp(Len8, 1'b0);
      7'd65: w = hn(Len8, 1'b1);
      // Letter c.
      7'd66: w = mk_org(5'd8, 5'd8);
      7'd67: w = hn(Len8, 1'b0);
      7'd68: w = vn(Len8, 1'b0);
      7'd69: w = hp(Len8, 1'b1);
      // Letter d.
      7'd70: w = mk_org(5'd8, 5'd16);
      7'd71: w = vn(Len16, 1'b0);
      7'd72: w = hn(Len8, 1'b0);
      7'd73: w = vp(Len8, 1'b0);
      7'd74: w = hp(Len8, 1'b1);
      // Letter e.
      7'd75: w = mk_org(5'd8, 5'd0);
      7'd76: w = hn(Len8, 1'b0);
      7'd77: w = vp(Len8, 1'b0);
      7'd78: w = vp(Len4, 1'b0);
      7'd79: w = hp(Len8, 1'b0);
      7'd80: w = vn(Len8, 1'b0);
      7'd81: w = hn(Len8, 1'b1);
      // Letter f.
      7'd82: w = mk_org(5'd0, 5'd0);
      7'd83: w = vp(Len8, 1'b0);
      7'd84: w = hp(Len4, 1'b0);
      7'd85: w = hn(Len4, 1'b0);
      7'd86: w = vp(Len8, 1'b0);
      7'd87: w = hp(Len4, 1'b1);
      // Unused addresses end the program at once.
      default: w = hp(LenW'(0), 1'b1);
    endcase
    return w;
  endfunction

  // Dispatch table: entry address of each glyph's program.
  function automatic logic [UpcW-1:0] glyph_entry(logic [3:0] code);
    logic [UpcW-1:0] a;
    case (code)
      4'h0:    a = 7'd0;
      4'h1:    a = 7'd5;
      4'h2:    a = 7'd8;
      4'h3:    a = 7'd14;
      4'h4:    a = 7'd21;
      4'h5:    a = 7'd26;
      4'h6:    a = 7'd32;
      4'h7:    a = 7'd38;
      4'h8:    a = 7'd41;
      4'h9:    a = 7'd49;
      4'hA:    a = 7'd54;
      4'hB:    a = 7'd61;
      4'hC:    a = 7'd66;
      4'hD:    a = 7'd70;
      4'hE:    a = 7'd75;
      default: a = 7'd82;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/hdvs_sequencer.sv
module hdvs_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3:0]          glyph_code_i,
  input  logic                out_free_i,
  output hdvs_pkg::dp_ctrl_t  ctrl_o
);
  import hdvs_pkg::*;

  state_e          state_q, state_d;
  logic [UpcW-1:0] upc_q, upc_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  ucode_t          cw;
  logic            accept;
  logic            run_stroke;
  logic            stroke_done;

  // Fetch the current control word.
  assign cw          = ucode_rom(upc_q);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign run_stroke  = (state_q == ST_RUN) && (cw.op == OP_STROKE) && out_free_i;
  assign stroke_done = run_stroke && (cnt_q == cw.len);

  // Next state: leave idle on a transfer, return after the final point.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (stroke_done && cw.eop) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control derived from the control word.
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.load    = accept;
    ctrl_o.add_off = (state_q == ST_RUN) && (cw.op == OP_ORG);
    ctrl_o.off_x   = cw.off_x;
    ctrl_o.off_y   = cw.off_y;
    ctrl_o.emit    = run_stroke;
    // The first point of a stroke repeats the start; later points move after.
    ctrl_o.step    = run_stroke && (cnt_q != '0);
    ctrl_o.axis_y  = cw.axis_y;
    ctrl_o.neg     = cw.neg;
    ctrl_o.last    = stroke_done && cw.eop;
  end

  // Step counter and microprogram counter.
  always_comb begin
    upc_d = upc_q;
    cnt_d = cnt_q;
    if (accept) begin
      upc_d = glyph_entry(glyph_code_i);
      cnt_d = '0;
    end else if (ctrl_o.add_off) begin
      upc_d = upc_q + 1'b1;
    end else if (stroke_done) begin
      cnt_d = '0;
      if (!cw.eop) upc_d = upc_q + 1'b1;
    end else if (run_stroke) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      upc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
      cnt_q   <= cnt_d;
    end
  end

  // The program counter never leaves the ROM.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q < UpcW'(RomDepth))
    else $error("microprogram counter outside ROM");

  // Every glyph program starts with an origin word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (cw.op == OP_ORG))
    else $error("glyph entry is not an origin word");

  // The point counter never runs past the stroke length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && (cw.op == OP_STROKE)) |-> (cnt_q <= cw.len))
    else $error("stroke counter overran");

  // The flagged point ends the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.last |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after the last point");

endmodule

>>> rtl/core/hdvs_datapath.sv
module hdvs_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hdvs_pkg::dp_ctrl_t  ctrl_i,
  input  logic [7:0]          origin_x_i,
  input  logic [7:0]          origin_y_i,
  output logic                out_free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hdvs_pkg::out_item_t out_item_o
);
  import hdvs_pkg::*;

  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;
  out_item_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] unit;

  // The output register can take a point when empty or being drained.
  assign out_free_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign unit        = ctrl_i.neg ? 8'hFF : 8'h01;

  // Beam position: load origin, add glyph offset, then unit steps.
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (ctrl_i.load) begin
      x_d = origin_x_i;
      y_d = origin_y_i;
    end else if (ctrl_i.add_off) begin
      x_d = x_q + {3'b000, ctrl_i.off_x};
      y_d = y_q + {3'b000, ctrl_i.off_y};
    end else if (ctrl_i.step) begin
      if (ctrl_i.axis_y) y_d = y_q + unit;
      else x_d = x_q + unit;
    end
  end

  // Output register holds the point taken before the move.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (ctrl_i.emit) begin
      out_d.beam_x     = x_q;
      out_d.beam_y     = y_q;
      out_d.last_point = ctrl_i.last;
      out_valid_d      = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      x_q         <= x_d;
      y_q         <= y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A point is only written when the register has room for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> out_free_o)
    else $error("point written over a pending transfer");

  // The beam never takes a unit step without a point going out in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step |-> ctrl_i.emit)
    else $error("beam moved without emitting a point");

  // The position holds while no control is active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl_i.load && !ctrl_i.add_off && !ctrl_i.step) |=> $stable(x_q) && $stable(y_q))
    else $error("beam position changed while idle");

endmodule

>>> rtl/core/hex_digit_vector_stroke_generator.sv
// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid_i / in_ready_o   | in_item_i  (origin_x, origin_y, glyph_code)
// output  | out       | out_valid_o / out_ready_i | out_item_o (beam_x, beam_y, last_point)
//
// A glyph of N points (N is 26 to 63) runs in steps: the transfer is taken, the
// microprogram's origin word is applied, then one point per cycle unless stalled.
// The ROM-driven sequencer runs one glyph at a time; the next item is taken
// the cycle after the last point enters the output register.
// Reset is asynchronous and active low; it empties the output register and
// returns the sequencer to idle. A stall on the output holds the sequencer.
module hex_digit_vector_stroke_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hdvs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hdvs_pkg::out_item_t out_item_o
);
  import hdvs_pkg::*;

  dp_ctrl_t ctrl;
  logic     out_free;

  // Microcoded control.
  hdvs_sequencer u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .glyph_code_i (in_item_i.glyph_code),
    .out_free_i   (out_free),
    .ctrl_o       (ctrl)
  );

  // Beam position and output register.
  hdvs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .origin_x_i  (in_item_i.origin_x),
    .origin_y_i  (in_item_i.origin_y),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
